// ===== hw/rtl/swedish_suffix_stemmer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Swedish suffix stemmer assertion macros
// Shared assertion helpers for the checker file of the stemmer core.
// ----------------------------------------------------------------------------
`ifndef SWEDISH_SUFFIX_STEMMER_CORE_DEFINES_SVH
`define SWEDISH_SUFFIX_STEMMER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SSS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SSS_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Swedish suffix stemmer package
// Widths, payload types and the word record passed from front to back end.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Saturation point of the byte counter.
  localparam int unsigned MAX_WORD_LEN = 255;
  localparam int unsigned LEN_W        = $clog2(MAX_WORD_LEN + 1);
  // Number of trailing bytes kept for suffix matching.
  localparam int unsigned TAIL_DEPTH   = 6;
  // Entries in the word queue between front and back end.
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } sss_in_t;

  typedef struct packed {
    logic [7:0] stem_length;
    logic       length_overflow;
  } sss_out_t;

  // One finished word: its last bytes (index 0 newest), length, overflow.
  typedef struct packed {
    logic [TAIL_DEPTH-1:0][7:0] tail;
    logic [LEN_W-1:0]           len;
    logic                       ovf;
  } sss_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sss_qstat_t;

endpackage

// ===== hw/rtl/sss_queue.sv =====
// ----------------------------------------------------------------------------
// Word queue
// Small register FIFO that decouples byte intake from suffix evaluation.
// ----------------------------------------------------------------------------
module sss_queue
  import sss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  sss_word_t  wr_data_i,
  input  logic       rd_en_i,
  output sss_word_t  rd_data_o,
  output sss_qstat_t stat_o
);

  sss_word_t mem_q [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_en_i && !wr_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== hw/rtl/sss_front.sv =====
// ----------------------------------------------------------------------------
// Stemmer front end
// Counts bytes, keeps the tail window and hands each finished word on.
// ----------------------------------------------------------------------------
module sss_front
  import sss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  sss_in_t    item_i,
  output logic       word_push_o,
  output sss_word_t  word_o
);

  logic [TAIL_DEPTH-1:0][7:0] tail_q, tail_d;
  logic [LEN_W-1:0]           len_q, len_d;
  logic                       ovf_q, ovf_d;

  logic [TAIL_DEPTH-1:0][7:0] tail_next;
  logic [LEN_W-1:0]           len_next;
  logic                       ovf_next;

  always_comb begin
    tail_next = {tail_q[TAIL_DEPTH-2:0], item_i.char_in};
    if (len_q < LEN_W'(MAX_WORD_LEN)) begin
      len_next = len_q + 1'b1;
      ovf_next = ovf_q;
    end else begin
      len_next = len_q;
      ovf_next = 1'b1;
    end

    tail_d = tail_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    if (accept_i) begin
      if (item_i.last_char) begin
        // word done: start the next one from scratch
        tail_d = '0;
        len_d  = '0;
        ovf_d  = 1'b0;
      end else begin
        tail_d = tail_next;
        len_d  = len_next;
        ovf_d  = ovf_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      tail_q <= tail_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

  assign word_push_o = accept_i && item_i.last_char;
  assign word_o.tail = tail_next;
  assign word_o.len  = len_next;
  assign word_o.ovf  = ovf_next;

endmodule

// ===== hw/rtl/sss_back.sv =====
// ----------------------------------------------------------------------------
// Stemmer back end
// Applies the suffix rules to a queued word and holds the result.
// ----------------------------------------------------------------------------
module sss_back
  import sss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sss_qstat_t qstat_i,
  input  sss_word_t  word_i,
  output logic       word_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output sss_out_t   result_o
);

  localparam int unsigned STEM_CMP_W = (LEN_W > 8) ? LEN_W : 8;

  logic       res_valid_q, res_valid_d;
  sss_out_t   res_q;
  logic       load;

  logic             s_strip;
  logic [LEN_W-1:0] len_s;
  logic [4:0][7:0]  view;
  logic [39:0]      e5;
  logic [31:0]      e4;
  logic [23:0]      e3;
  logic [15:0]      e2;
  logic [7:0]       e1;
  logic [2:0]       strip;
  logic [LEN_W-1:0] stem;
  logic [STEM_CMP_W-1:0] stem_ext;

  always_comb begin
    s_strip = (word_i.len >= LEN_W'(5)) && (word_i.tail[0] == "s");
    len_s   = s_strip ? word_i.len - 1'b1 : word_i.len;
    for (int k = 0; k < 5; k++) begin
      view[k] = s_strip ? word_i.tail[k+1] : word_i.tail[k];
    end
    e5 = view;
    e4 = e5[31:0];
    e3 = e5[23:0];
    e2 = e5[15:0];
    e1 = e5[7:0];

    // groups in order of priority; thresholds fall with the suffix length
    if (len_s >= LEN_W'(8) && (e5 == "elser" || e5 == "heten")) begin
      strip = 3'd5;
    end else if (len_s >= LEN_W'(7) &&
                 (e4 == "arne" || e4 == "erna" || e4 == "ande" || e4 == "else" ||
                  e4 == "aste" || e4 == "orna" || e4 == "aren")) begin
      strip = 3'd4;
    end else if (len_s >= LEN_W'(6) &&
                 (e3 == "are" || e3 == "ast" || e3 == "het")) begin
      strip = 3'd3;
    end else if (len_s >= LEN_W'(5) &&
                 (e2 == "ar" || e2 == "or" || e2 == "er" || e2 == "en" ||
                  e2 == "at" || e2 == "te" || e2 == "et")) begin
      strip = 3'd2;
    end else if (len_s >= LEN_W'(4) &&
                 (e1 == "t" || e1 == "a" || e1 == "e" || e1 == "n")) begin
      strip = 3'd1;
    end else begin
      strip = 3'd0;
    end

    stem     = len_s - LEN_W'(strip);
    stem_ext = STEM_CMP_W'(stem);
  end

  assign load        = !qstat_i.empty && (!res_valid_q || pop_i);
  assign word_pop_o  = load;

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.stem_length     <= (stem_ext > STEM_CMP_W'(255)) ? 8'hFF : stem_ext[7:0];
      res_q.length_overflow <= word_i.ovf;
    end
  end

  assign empty_o  = !res_valid_q;
  assign result_o = res_q;

endmodule

// ===== hw/rtl/swedish_suffix_stemmer_core.sv =====
// ----------------------------------------------------------------------------
// Swedish suffix stemmer core
// Streaming light stemmer: bytes in, stem length out, one result per word.
// ----------------------------------------------------------------------------
// Feed a word one byte per transaction, setting last_char on its final byte;
// one result (stem length and overflow flag) comes out per word, in order.
// Intake runs at one byte per clock while full is low, with no gaps between
// words. A word's result goes through the word queue and then the result
// register when nothing is backed up. full rises only when the two-entry
// word queue is full, which happens only when results are not popped; bytes
// of a word that is not yet finished do not take queue space, but full is
// raised on the queue level alone. No reset sweep: the block is ready right
// after reset is released.
// ----------------------------------------------------------------------------
module swedish_suffix_stemmer_core
  import sss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  // byte side
  input  logic     push,
  output logic     full,
  input  sss_in_t  in_item_i,
  // result side
  output logic     empty,
  input  logic     pop,
  output sss_out_t result_o
);

  logic       accept;
  logic       word_push;
  logic       word_pop;
  sss_word_t  word_in;
  sss_word_t  word_out;
  sss_qstat_t qstat;

  // a byte transaction completes whenever the queue has room
  assign accept = push && !full;
  assign full   = qstat.full;

  // front end: length counter, six byte tail window, overflow flag
  sss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .word_push_o(word_push),
    .word_o     (word_in)
  );

  // finished words wait here while the result register is occupied
  sss_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (word_push),
    .wr_data_i(word_in),
    .rd_en_i  (word_pop),
    .rd_data_o(word_out),
    .stat_o   (qstat)
  );

  // back end: 's' removal, rule match, registered result
  sss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qstat_i   (qstat),
    .word_i    (word_out),
    .word_pop_o(word_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

// ===== hw/rtl/sss_checker.sv =====
// ----------------------------------------------------------------------------
// Stemmer port checker
// Watches the core's ports for result hold, stem length bounds and queue fill.
// ----------------------------------------------------------------------------
`include "swedish_suffix_stemmer_core_defines.svh"

module sss_checker
  import sss_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input sss_in_t  in_item_i,
  input logic     empty,
  input logic     pop,
  input sss_out_t result_o
);

  // an overflowed word keeps at least the saturated count minus six bytes
  localparam int unsigned OVF_MIN =
    (MAX_WORD_LEN - 6 > 255) ? 255 : MAX_WORD_LEN - 6;

  logic in_seen;
  assign in_seen = push && !full && in_item_i.last_char;

  `SSS_ASSERT(a_result_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(result_o), "result changed before pop")
  `SSS_ASSERT_NEVER(a_stem_nonzero, clk_i, rst_ni, !empty && result_o.stem_length == 8'd0, "zero stem length")
  `SSS_ASSERT(a_ovf_floor, clk_i, rst_ni, !empty && result_o.length_overflow |-> result_o.stem_length >= 8'(OVF_MIN), "overflowed word stem too short")
  `SSS_ASSERT(a_no_full_after_pop, clk_i, rst_ni, full && !in_seen && $past(!empty && pop) |-> $past(full), "queue filled without a word end")

endmodule

bind swedish_suffix_stemmer_core sss_checker u_sss_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .in_item_i(in_item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
